[src/assert_macros.svh]
// Assertion macros shared by the RTL that carries checks.
// Each macro expects clk and rst to be in scope of the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tcae_pkg.sv]
// Shared types, character constants and helper functions for the
// terminal cell encoder. No dependencies.
package tcae_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_start;
  } texel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       cell_done;
  } stream_t;

  // Fully evaluated cell, handed from the arithmetic pipe to the serializer.
  typedef struct packed {
    logic [7:0]  ramp_char;
    logic [23:0] rgb;
    logic [35:0] digits;   // red, green, blue; hundreds, tens, ones each
    logic        frame_start;
  } cell_t;

  localparam int unsigned RampLen = 66;
  localparam logic [RampLen*8-1:0] Ramp =
    " `^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

  localparam int unsigned SeqLen = 20;
  localparam logic [4:0]  SeqLast = 5'(SeqLen - 1);

  localparam logic [7:0] ChEsc     = 8'h1B;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChFour    = 8'h34;
  localparam logic [7:0] ChEight   = 8'h38;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [7:0] ChM       = 8'h6D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;

  // luminance index = floor(n / LumDiv), n = (r+g+b)*a*65
  localparam logic [17:0] LumDiv   = 18'd195075;
  localparam logic [14:0] LumRecip = 15'd22017;   // floor(2^32 / LumDiv)

  function automatic logic [7:0] ramp_char(input logic [6:0] idx);
    logic [6:0] i;
    logic [9:0] bit_pos;
    i = (idx > 7'(RampLen - 1)) ? 7'(RampLen - 1) : idx;
    bit_pos = {7'(RampLen - 1) - i, 3'b000};
    return Ramp[bit_pos +: 8];
  endfunction

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [11:0] dec3(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] m;
    logic [3:0]  t;
    logic [3:0]  o;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    m = 15'(r) * 15'd205;   // r/10 for r < 100
    t = m[14:11];
    o = 4'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o};
  endfunction

endpackage

[src/tcae_math.sv]
// Three-stage arithmetic pipe: premultiply, luminance index, decimal digits.
// Depends on tcae_pkg.
module tcae_math (
  input  logic            clk,
  input  logic            rst,
  input  tcae_pkg::texel_t texel,
  input  logic            texel_valid,
  output logic            texel_stall,
  output tcae_pkg::cell_t cell_data,
  output logic            cell_valid,
  input  logic            cell_stall
);
  import tcae_pkg::*;

  // stage 1: captured texel
  texel_t      s1;
  logic        v1;
  // stage 2: products
  logic [17:0] s2_lum;
  logic [15:0] s2_pr;
  logic [15:0] s2_pg;
  logic [15:0] s2_pb;
  logic        s2_fs;
  logic        v2;
  // stage 3: scaled luminance, reciprocal estimate, premultiplied channels
  logic [23:0] s3_n;
  logic [6:0]  s3_q;
  logic [7:0]  s3_r;
  logic [7:0]  s3_g;
  logic [7:0]  s3_b;
  logic        s3_fs;
  logic        v3;

  logic        ready1;
  logic        ready2;
  logic        ready3;
  logic [9:0]  sum;
  logic [23:0] n_next;
  logic [38:0] est;
  logic [23:0] rem;
  logic [6:0]  idx;

  assign ready3 = !v3 || !cell_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign texel_stall = !ready1;

  assign sum    = 10'(s1.red) + 10'(s1.green) + 10'(s1.blue);
  assign n_next = 24'({s2_lum, 6'b000000}) + 24'(s2_lum);
  assign est    = 39'(n_next) * 39'(LumRecip);

  // estimate is low by at most one
  assign rem = s3_n - 24'(s3_q) * 24'(LumDiv);
  assign idx = s3_q + 7'(rem >= 24'(LumDiv));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= texel_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) s1 <= texel;
    if (ready2) begin
      s2_lum <= 18'(sum) * 18'(s1.alpha);
      s2_pr  <= 16'(s1.red) * 16'(s1.alpha);
      s2_pg  <= 16'(s1.green) * 16'(s1.alpha);
      s2_pb  <= 16'(s1.blue) * 16'(s1.alpha);
      s2_fs  <= s1.frame_start;
    end
    if (ready3) begin
      s3_n  <= n_next;
      s3_q  <= est[38:32];
      s3_r  <= div255(s2_pr);
      s3_g  <= div255(s2_pg);
      s3_b  <= div255(s2_pb);
      s3_fs <= s2_fs;
    end
  end

  assign cell_valid            = v3;
  assign cell_data.ramp_char   = ramp_char(idx);
  assign cell_data.rgb         = {s3_r, s3_g, s3_b};
  assign cell_data.digits      = {dec3(s3_r), dec3(s3_g), dec3(s3_b)};
  assign cell_data.frame_start = s3_fs;

endmodule

[src/tcae_emit.sv]
// Byte serializer: holds one cell, tracks the last color sent and walks
// the escape sequence one byte per transfer. Depends on tcae_pkg.
module tcae_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             colored_mode,
  input  tcae_pkg::cell_t  cell_data,
  input  logic             cell_valid,
  output logic             cell_stall,
  output tcae_pkg::stream_t stream,
  output logic             stream_valid,
  input  logic             stream_stall
);
  import tcae_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic        full;        // sending the whole color sequence
  logic [7:0]  single;      // the one byte of a short cell
  logic [35:0] digits;
  logic [23:0] prev_rgb;

  logic        xfer;
  logic        last;
  logic        load;
  logic [23:0] prev_eff;
  logic        differ;
  logic [3:0]  dig;
  logic [7:0]  seq_byte;

  assign last       = !full || (cnt == SeqLast);
  assign xfer       = busy && !stream_stall;
  assign cell_stall = busy && !(xfer && last);
  assign load       = cell_valid && !cell_stall;

  assign prev_eff = cell_data.frame_start ? 24'h000000 : prev_rgb;
  assign differ   = cell_data.rgb != prev_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      prev_rgb <= 24'h000000;
    end else if (load) begin
      busy <= 1'b1;
      if (colored_mode && differ) prev_rgb <= cell_data.rgb;
      else                        prev_rgb <= prev_eff;
    end else if (xfer && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt    <= 5'd0;
      full   <= colored_mode && differ;
      single <= colored_mode ? ChSpace : cell_data.ramp_char;
      digits <= cell_data.digits;
    end else if (xfer) begin
      cnt <= cnt + 5'd1;
    end
  end

  always_comb begin
    dig      = 4'd0;
    seq_byte = ChSpace;
    unique case (cnt)
      5'd0:  seq_byte = ChEsc;
      5'd1:  seq_byte = ChBracket;
      5'd2:  seq_byte = ChFour;
      5'd3:  seq_byte = ChEight;
      5'd4:  seq_byte = ChSemi;
      5'd5:  seq_byte = ChTwo;
      5'd6:  seq_byte = ChSemi;
      5'd7:  dig = digits[35:32];
      5'd8:  dig = digits[31:28];
      5'd9:  dig = digits[27:24];
      5'd10: seq_byte = ChSemi;
      5'd11: dig = digits[23:20];
      5'd12: dig = digits[19:16];
      5'd13: dig = digits[15:12];
      5'd14: seq_byte = ChSemi;
      5'd15: dig = digits[11:8];
      5'd16: dig = digits[7:4];
      5'd17: dig = digits[3:0];
      5'd18: seq_byte = ChM;
      default: seq_byte = ChSpace;
    endcase
    if ((cnt >= 5'd7 && cnt <= 5'd9) || (cnt >= 5'd11 && cnt <= 5'd13) ||
        (cnt >= 5'd15 && cnt <= 5'd17)) begin
      seq_byte = ChZero | {4'b0000, dig};
    end
  end

  assign stream_valid     = busy;
  assign stream.out_byte  = full ? seq_byte : single;
  assign stream.cell_done = last;

endmodule

[src/terminal_cell_ansi_encoder_unit.sv]
// A texel passes s1, s2 and s3 in tcae_math, then is loaded into tcae_emit.
// Throughput: one texel per cycle into the pipe unless texel_stall is high;
// one output byte per cycle unless stream_stall is high. An ASCII cell or a
// repeated color is one byte, a new color the 20-byte escape sequence.
// Reset (rst, synchronous): empties the pipe, mode ASCII, last color black.
// Uses tcae_pkg, tcae_math, tcae_emit and assert_macros.svh.
`include "assert_macros.svh"

module terminal_cell_ansi_encoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  tcae_pkg::texel_t  texel,
  input  logic              texel_valid,
  output logic              texel_stall,
  output tcae_pkg::stream_t stream,
  output logic              stream_valid,
  input  logic              stream_stall
);
  import tcae_pkg::*;

  logic  colored_mode;
  cell_t cell_data;
  logic  cell_valid;
  logic  cell_stall;

  always_ff @(posedge clk) begin
    if (rst) colored_mode <= 1'b0;
    else if (cfg_write) colored_mode <= cfg_data;
  end

  tcae_math u_math (
    .clk        (clk),
    .rst        (rst),
    .texel      (texel),
    .texel_valid(texel_valid),
    .texel_stall(texel_stall),
    .cell_data  (cell_data),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall)
  );

  tcae_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .colored_mode(colored_mode),
    .cell_data   (cell_data),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .stream      (stream),
    .stream_valid(stream_valid),
    .stream_stall(stream_stall)
  );

  // a sequence in flight keeps going after each non-final transfer
  `ASSERT_NEXT(a_seq_continues, stream_valid && !stream_stall && !stream.cell_done, stream_valid, "sequence broke off")
  // only the final byte of a cell may be a space
  `ASSERT_IMPL(a_no_inner_space, stream_valid && !stream.cell_done, stream.out_byte != ChSpace, "inner space")
  // a finished cell waiting on the serializer stays offered
  `ASSERT_NEXT(a_cell_held, cell_valid && cell_stall, cell_valid, "cell dropped while busy")

endmodule

[tb/terminal_cell_ansi_encoder_unit_tb.sv]
// Testbench for terminal_cell_ansi_encoder_unit: drives texels, predicts the byte
// stream in both modes and checks every output transfer in order.
// Depends on tcae_pkg (texel_t, stream_t) and the encoder RTL.
module terminal_cell_ansi_encoder_unit_tb;
  import tcae_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [7:0]  Digit0        = 8'h30;
  localparam logic [7:0]  EscChar       = 8'h1B;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic              cfg_data;
  texel_t            texel;
  logic              texel_valid;
  logic              texel_stall;
  stream_t           stream;
  logic              stream_valid;
  logic              stream_stall;

  // Predictor state
  string             lum_chars =
    " `^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";
  bit                colored_on;
  logic [23:0]       last_color;
  stream_t           expected_bytes[$];
  texel_t            last_sent;

  bit                tx_gaps_on;
  bit                rx_stalls_on;
  int                stall_hold;
  int                errors;
  int unsigned       idle_cycles;

  terminal_cell_ansi_encoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .texel        (texel),
    .texel_valid  (texel_valid),
    .texel_stall  (texel_stall),
    .stream       (stream),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_byte(logic [7:0] ch, logic last);
    stream_t e;
    e.out_byte  = ch;
    e.cell_done = last;
    expected_bytes.insert(expected_bytes.size(), e);
  endfunction

  function automatic void push_dec3(logic [7:0] v);
    push_byte(Digit0 + 8'(v / 100), 1'b0);
    push_byte(Digit0 + 8'((v / 10) % 10), 1'b0);
    push_byte(Digit0 + 8'(v % 10), 1'b0);
  endfunction

  function automatic void encode_cell(texel_t t);
    int unsigned lum;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
    logic [23:0] rgb;
    if (t.frame_start) last_color = '0;
    if (!colored_on) begin
      lum = ((32'(t.red) + 32'(t.green) + 32'(t.blue)) * 32'(t.alpha) * 32'd65) / 32'd195075;
      if (lum > 65) lum = 65;
      push_byte(8'(lum_chars[lum]), 1'b1);
    end else begin
      pr  = 8'((32'(t.red) * 32'(t.alpha)) / 32'd255);
      pg  = 8'((32'(t.green) * 32'(t.alpha)) / 32'd255);
      pb  = 8'((32'(t.blue) * 32'(t.alpha)) / 32'd255);
      rgb = {pr, pg, pb};
      if (rgb == last_color) begin
        push_byte(" ", 1'b1);
      end else begin
        last_color = rgb;
        push_byte(EscChar, 1'b0);
        push_byte("[", 1'b0);
        push_byte("4", 1'b0);
        push_byte("8", 1'b0);
        push_byte(";", 1'b0);
        push_byte("2", 1'b0);
        push_byte(";", 1'b0);
        push_dec3(pr);
        push_byte(";", 1'b0);
        push_dec3(pg);
        push_byte(";", 1'b0);
        push_dec3(pb);
        push_byte("m", 1'b0);
        push_byte(" ", 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_cell(texel_t t);
    int gap;
    gap = tx_gaps_on ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      texel_valid = 1'b0;
    end
    @(negedge clk);
    texel       = t;
    texel_valid = 1'b1;
    @(posedge clk);
    while (texel_stall) @(posedge clk);
    encode_cell(t);
    last_sent = t;
  endtask

  task automatic send_rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                           logic fs);
    texel_t t;
    t.red         = r;
    t.green       = g;
    t.blue        = b;
    t.alpha       = a;
    t.frame_start = fs;
    send_cell(t);
  endtask

  // Register writes only once every expected byte is out and the pipe has drained
  task automatic set_mode(bit colored);
    @(negedge clk);
    texel_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = colored;
    @(posedge clk);
    colored_on = colored;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
  endtask

  function automatic texel_t random_texel();
    texel_t t;
    int     p;
    p = $urandom_range(0, 99);
    if (p < 25) begin
      t = last_sent;   // repeat color, usually the space path
    end else begin
      t.red   = 8'($urandom);
      t.green = 8'($urandom);
      t.blue  = 8'($urandom);
      p = $urandom_range(0, 99);
      if (p < 15)      t.alpha = 8'd0;
      else if (p < 30) t.alpha = 8'd255;
      else             t.alpha = 8'($urandom);
    end
    t.frame_start = ($urandom_range(0, 19) == 0);
    return t;
  endfunction

  task automatic test_ascii_ramp();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_rgba(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);   // top of the ramp
    send_rgba(8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
    send_rgba(8'd1,   8'd0,   8'd0,   8'd255, 1'b0);
    send_rgba(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
    send_rgba(8'd128, 8'd64,  8'd32,  8'd200, 1'b0);
  endtask

  task automatic test_colored_sequences();
    set_mode(1'b1);
    send_rgba(8'd200, 8'd100, 8'd50,  8'd0,   1'b1);   // transparent on black
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_rgba(8'd10,  8'd20,  8'd30,  8'd0,   1'b0);   // transparent after white
    send_rgba(8'd9,   8'd99,  8'd100, 8'd255, 1'b0);
    send_rgba(8'd9,   8'd99,  8'd100, 8'd255, 1'b1);   // frame start forgets color
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255, 1'b1);
    send_rgba(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
  endtask

  task automatic test_mode_switch_in_frame();
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    set_mode(1'b0);
    send_rgba(8'd17,  8'd34,  8'd51,  8'd68,  1'b0);
    set_mode(1'b1);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);   // color kept across ASCII
    set_mode(1'b0);
    send_rgba(8'd90,  8'd90,  8'd90,  8'd90,  1'b1);   // frame start in ASCII mode
    set_mode(1'b1);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
  endtask

  task automatic test_random_cells(bit colored, int count, bit gaps, bit stalls);
    set_mode(colored);
    tx_gaps_on   = gaps;
    rx_stalls_on = stalls;
    repeat (count) send_cell(random_texel());
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst || !rx_stalls_on) begin
      stall_hold = 0;
      stream_stall <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
      stream_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_hold = gap_len();
      stream_stall <= 1'b1;
    end else begin
      stream_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    stream_t exp_b;
    if (!rst && stream_valid && !stream_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h done %0b",
                                  stream.out_byte, stream.cell_done));
      end else begin
        exp_b = expected_bytes.pop_front();
        if (stream.out_byte !== exp_b.out_byte)
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                    stream.out_byte, exp_b.out_byte));
        if (stream.cell_done !== exp_b.cell_done)
          report_mismatch($sformatf("cell_done %0b, expected %0b (byte 0x%02h)",
                                    stream.cell_done, exp_b.cell_done, exp_b.out_byte));
      end
    end
  end

  // Any cycle without a transfer on either side counts toward the limit
  always @(posedge clk) begin
    if (rst || (texel_valid && !texel_stall) || (stream_valid && !stream_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
                 idle_cycles, expected_bytes.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = 1'b0;
    texel        = '0;
    texel_valid  = 1'b0;
    stream_stall = 1'b0;
    colored_on   = 1'b0;
    last_color   = '0;
    last_sent    = '0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    stall_hold   = 0;
    errors       = 0;
    idle_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ascii_ramp();
    test_colored_sequences();
    test_mode_switch_in_frame();
    test_random_cells(1'b1, 50, 1'b1, 1'b1);
    test_random_cells(1'b0, 30, 1'b1, 1'b1);
    test_random_cells(1'b1, 35, 1'b0, 1'b0);
    test_random_cells(1'b0, 15, 1'b0, 1'b1);
    test_random_cells(1'b1, 20, 1'b1, 1'b0);

    @(negedge clk);
    texel_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
